// ===== design/ihpl_pkg.sv =====
// Shared types, constants and helpers of the hex page loader.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none

package ihpl_pkg;

   // ASCII start-of-record mark
   localparam logic [7:0] START_CHAR  = 8'h3A;
   // content of an erased (never written) buffer byte
   localparam logic [7:0] ERASED_BYTE = 8'hFF;
   // record type that ends the file
   localparam logic [7:0] REC_EOF     = 8'h01;

   // record parser phases
   typedef enum logic [6:0] {
      PH_START    = 7'b0000001,
      PH_SIZE     = 7'b0000010,
      PH_ADDRESS  = 7'b0000100,
      PH_TYPE     = 7'b0001000,
      PH_DATA     = 7'b0010000,
      PH_CHECKSUM = 7'b0100000,
      PH_ERROR    = 7'b1000000
   } ihpl_phase_type;

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_REPORT  = 4'b0010,
      ST_DUMP_RD = 4'b0100,
      ST_DUMP_WR = 4'b1000
   } ihpl_state_type;

   typedef struct packed {
      logic step;          // parse the accepted character
      logic load_status;   // load a status-only result
      logic load_word;     // load the current page word
      logic word_next;     // advance to the next page word
      logic dump_end;      // page dump finished, erase the buffer
   } ihpl_cmd_type;

   typedef struct packed {
      logic dump_pend;     // last character asked for a page dump
      logic word_last;     // current word is the last of the page
      logic chk_err;
      logic done;
   } ihpl_sts_type;

   // non-hex characters count as zero
   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [3:0] v;
      v = 4'h0;
      if (c >= 8'h30 && c <= 8'h39) begin        // '0'..'9'
         v = 4'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin // 'A'..'F'
         v = 4'(c - 8'h37);
      end else if (c >= 8'h61 && c <= 8'h66) begin // 'a'..'f'
         v = 4'(c - 8'h57);
      end
      return v;
   endfunction

endpackage

`default_nettype wire

// ===== design/intel_hex_page_loader.sv =====
// Intel HEX page loader: parses hex text one character per transaction and
// emits buffered pages as 16-bit little-endian words. Depends on ihpl_pkg,
// ihpl_ctrl, ihpl_dp and ihpl_ram.
//
// Every accepted character yields one status result, loaded into the output
// register from the report state, except one that completes a page or the
// end-of-file record: it yields the whole page instead, (PAGE_BYTES+1)/2
// words, each read from RAM and then loaded into the output register, with
// output stalls holding the dump. A new character is taken once the previous
// result is loaded into the output register. The page buffer is erased by
// clearing all per-byte written flags together; there is no clearing pass.
// A bad checksum locks the parser in an error state; after end of file all
// characters are ignored. The page base comes from the first record address
// after reset or after a full page, aligned down to PAGE_BYTES.
`default_nettype none

module intel_hex_page_loader #(
   parameter int PAGE_BYTES = 128
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_char_in,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_word_valid,
   output logic [15:0]      rsp_page_address,
   output logic [6:0]       rsp_word_offset,
   output logic [15:0]      rsp_word_data,
   output logic             rsp_last_word,
   output logic             rsp_checksum_error,
   output logic             rsp_load_done
);
   import ihpl_pkg::*;

   ihpl_cmd_type cmd;
   ihpl_sts_type sts;

   ihpl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ihpl_dp #(
      .PAGE_BYTES (PAGE_BYTES)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_char_in        (req_char_in),
      .cmd                (cmd),
      .sts                (sts),
      .rsp_word_valid     (rsp_word_valid),
      .rsp_page_address   (rsp_page_address),
      .rsp_word_offset    (rsp_word_offset),
      .rsp_word_data      (rsp_word_data),
      .rsp_last_word      (rsp_last_word),
      .rsp_checksum_error (rsp_checksum_error),
      .rsp_load_done      (rsp_load_done)
   );

   // a status-only result always closes its transaction group
   a_status_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_word_valid) |-> rsp_last_word)
      else $error("status result without last_word");

   // no new character while a page dump is pending
   a_no_accept_in_dump: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !sts.dump_pend)
      else $error("input ready during page dump");

   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      !$fell(sts.chk_err))
      else $error("checksum error cleared");

   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      !$fell(sts.done))
      else $error("load done cleared");

endmodule

`default_nettype wire

// ===== design/ihpl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the page buffer halves.
`default_nettype none

module ihpl_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/ihpl_ctrl.sv =====
// Controller of the hex page loader: handshakes and sequencing of the
// status result and of page dumps. Depends on ihpl_pkg.
`default_nettype none

module ihpl_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire ihpl_pkg::ihpl_sts_type sts,
   output ihpl_pkg::ihpl_cmd_type     cmd
);
   import ihpl_pkg::*;

   ihpl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      out_free  = !rsp_valid_ff || rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.step = 1'b1;
               state_in = ST_REPORT;
            end
         end
         ST_REPORT: begin
            if (sts.dump_pend) begin
               state_in = ST_DUMP_RD;
            end else if (out_free) begin
               cmd.load_status = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_DUMP_RD: begin
            state_in = ST_DUMP_WR;
         end
         ST_DUMP_WR: begin
            if (out_free) begin
               cmd.load_word = 1'b1;
               if (sts.word_last) begin
                  cmd.dump_end = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  cmd.word_next = 1'b1;
                  state_in      = ST_DUMP_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cmd.load_status || cmd.load_word) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== design/ihpl_dp.sv =====
// Datapath of the hex page loader: record parser, page buffer with erase
// flags, page base alignment and the result register. Depends on ihpl_pkg
// and ihpl_ram.
`default_nettype none

module ihpl_dp #(
   parameter int PAGE_BYTES = 128
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [7:0]             req_char_in,
   input  wire ihpl_pkg::ihpl_cmd_type cmd,
   output ihpl_pkg::ihpl_sts_type      sts,
   output logic                        rsp_word_valid,
   output logic [15:0]                 rsp_page_address,
   output logic [6:0]                  rsp_word_offset,
   output logic [15:0]                 rsp_word_data,
   output logic                        rsp_last_word,
   output logic                        rsp_checksum_error,
   output logic                        rsp_load_done
);
   import ihpl_pkg::*;

   localparam int WORDS = (PAGE_BYTES + 1) / 2;
   localparam int KW    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int OFF_W = KW + 1;
   // floor(2^16 / PAGE_BYTES); quotient estimate is at most one low
   localparam int RECIP = 65536 / PAGE_BYTES;

   // parser state
   ihpl_phase_type   phase_ff, phase_in;
   logic             running_ff, running_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic [11:0]      acc_ff, acc_in;
   logic [7:0]       size_ff, size_in;
   logic             eof_ff, eof_in;
   logic [7:0]       sum_ff, sum_in;
   logic [7:0]       bytes_ff, bytes_in;
   logic [OFF_W-1:0] fill_ff, fill_in;
   logic             need_base_ff, need_base_in;
   logic             dump_ff, dump_in;

   // page base alignment pipeline
   logic [15:0]      addr_ff;
   logic             addr_cap;
   logic [1:0]       base_pend_ff;
   logic [15:0]      quot_ff;
   logic [31:0]      quot_prod;
   logic [23:0]      base_lo;
   logic [23:0]      base_rem;
   logic [15:0]      base_aligned;
   logic [15:0]      page_base_ff;

   // buffer
   logic [2*WORDS-1:0] vld_ff;
   logic               wr_en;
   logic [KW-1:0]      word_ff;
   logic [7:0]         ram_lo, ram_hi;
   logic [OFF_W-1:0]   off_lo, off_hi;
   logic [7:0]         byte_lo, byte_hi;

   // parser datapath
   logic [3:0]       digit;
   logic [15:0]      acc_full;
   logic [7:0]       b;
   logic             field_done;
   logic [7:0]       sum_chk;
   logic [OFF_W:0]   fill_inc;
   logic [7:0]       bytes_inc;

   // result register
   logic        word_valid_ff;
   logic [15:0] page_addr_ff;
   logic [6:0]  offset_ff;
   logic [15:0] data_ff;
   logic        last_ff;
   logic        err_ff;
   logic        done_ff;

   always_comb begin
      digit      = hex_value(req_char_in);
      acc_full   = {acc_ff, digit};
      b          = acc_full[7:0];
      field_done = (phase_ff == PH_ADDRESS) ? (cnt_ff == 2'd3) : (cnt_ff == 2'd1);
      sum_chk    = sum_ff + b;
      fill_inc   = {1'b0, fill_ff} + (OFF_W+1)'(1);
      bytes_inc  = bytes_ff + 8'd1;

      phase_in     = phase_ff;
      running_in   = running_ff;
      cnt_in       = cnt_ff;
      acc_in       = acc_ff;
      size_in      = size_ff;
      eof_in       = eof_ff;
      sum_in       = sum_ff;
      bytes_in     = bytes_ff;
      fill_in      = fill_ff;
      need_base_in = need_base_ff;
      dump_in      = dump_ff;
      wr_en        = 1'b0;
      addr_cap     = 1'b0;

      if (cmd.step && running_ff) begin
         if (phase_ff == PH_START) begin
            if (req_char_in == START_CHAR) begin
               phase_in = PH_SIZE;
               cnt_in   = 2'd0;
               acc_in   = 12'd0;
               sum_in   = 8'd0;
            end
         end else if (phase_ff != PH_ERROR) begin
            acc_in = acc_full[11:0];
            cnt_in = cnt_ff + 2'd1;
            if (field_done) begin
               acc_in = 12'd0;
               cnt_in = 2'd0;
               unique case (phase_ff)
                  PH_SIZE: begin
                     size_in  = b;
                     sum_in   = sum_chk;
                     phase_in = PH_ADDRESS;
                  end
                  PH_ADDRESS: begin
                     sum_in = sum_chk + acc_full[15:8];
                     if (need_base_ff) begin
                        addr_cap     = 1'b1;
                        need_base_in = 1'b0;
                     end
                     phase_in = PH_TYPE;
                  end
                  PH_TYPE: begin
                     eof_in   = (b == REC_EOF);
                     sum_in   = sum_chk;
                     bytes_in = 8'd0;
                     phase_in = (b == REC_EOF || size_ff == 8'd0) ? PH_CHECKSUM : PH_DATA;
                  end
                  PH_DATA: begin
                     wr_en    = 1'b1;
                     sum_in   = sum_chk;
                     bytes_in = bytes_inc;
                     if (bytes_inc == size_ff) begin
                        phase_in = PH_CHECKSUM;
                        bytes_in = 8'd0;
                     end
                     if (fill_inc == (OFF_W+1)'(PAGE_BYTES)) begin
                        dump_in      = 1'b1;
                        fill_in      = '0;
                        need_base_in = 1'b1;
                     end else begin
                        fill_in = fill_inc[OFF_W-1:0];
                     end
                  end
                  PH_CHECKSUM: begin
                     sum_in = sum_chk;
                     if (eof_ff) begin
                        dump_in    = 1'b1;
                        running_in = 1'b0;
                     end
                     phase_in = (sum_chk == 8'd0) ? PH_START : PH_ERROR;
                  end
                  default: begin
                  end
               endcase
            end
         end
      end
      if (cmd.dump_end) begin
         dump_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         running_ff   <= 1'b1;
         cnt_ff       <= 2'd0;
         acc_ff       <= 12'd0;
         size_ff      <= 8'd0;
         eof_ff       <= 1'b0;
         sum_ff       <= 8'd0;
         bytes_ff     <= 8'd0;
         fill_ff      <= '0;
         need_base_ff <= 1'b1;
         dump_ff      <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         running_ff   <= running_in;
         cnt_ff       <= cnt_in;
         acc_ff       <= acc_in;
         size_ff      <= size_in;
         eof_ff       <= eof_in;
         sum_ff       <= sum_in;
         bytes_ff     <= bytes_in;
         fill_ff      <= fill_in;
         need_base_ff <= need_base_in;
         dump_ff      <= dump_in;
      end
   end

   // page base = addr - addr % PAGE_BYTES, in registered steps:
   // reciprocal quotient estimate, then multiply back and correct once
   assign quot_prod    = 32'(addr_ff) * 32'(RECIP);
   assign base_lo      = 24'(quot_ff) * 24'(PAGE_BYTES);
   assign base_rem     = 24'(addr_ff) - base_lo;
   assign base_aligned = (base_rem >= 24'(PAGE_BYTES)) ?
                         16'(base_lo + 24'(PAGE_BYTES)) : base_lo[15:0];

   always_ff @(posedge clock) begin
      if (addr_cap) begin
         addr_ff <= acc_full;
      end
      quot_ff <= quot_prod[31:16];
      if (reset) begin
         base_pend_ff <= 2'b00;
         page_base_ff <= 16'd0;
      end else begin
         base_pend_ff <= {base_pend_ff[0], addr_cap};
         if (base_pend_ff[1]) begin
            page_base_ff <= base_aligned;
         end
      end
   end

   // even and odd bytes of the page live in separate RAMs
   ihpl_ram #(
      .WIDTH (8),
      .DEPTH (WORDS)
   ) u_ram_lo (
      .clock   (clock),
      .wr_en   (wr_en && !fill_ff[0]),
      .wr_addr (fill_ff[OFF_W-1:1]),
      .wr_data (b),
      .rd_addr (word_ff),
      .rd_data (ram_lo)
   );

   ihpl_ram #(
      .WIDTH (8),
      .DEPTH (WORDS)
   ) u_ram_hi (
      .clock   (clock),
      .wr_en   (wr_en && fill_ff[0]),
      .wr_addr (fill_ff[OFF_W-1:1]),
      .wr_data (b),
      .rd_addr (word_ff),
      .rd_data (ram_hi)
   );

   // written flags: an unwritten byte reads as erased
   always_ff @(posedge clock) begin
      if (reset || cmd.dump_end) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[fill_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff <= '0;
      end else if (cmd.step) begin
         word_ff <= '0;
      end else if (cmd.word_next) begin
         word_ff <= word_ff + KW'(1);
      end
   end

   assign off_lo  = {word_ff, 1'b0};
   assign off_hi  = {word_ff, 1'b1};
   assign byte_lo = vld_ff[off_lo] ? ram_lo : ERASED_BYTE;
   assign byte_hi = vld_ff[off_hi] ? ram_hi : ERASED_BYTE;

   always_ff @(posedge clock) begin
      if (cmd.load_status) begin
         word_valid_ff <= 1'b0;
         page_addr_ff  <= 16'd0;
         offset_ff     <= 7'd0;
         data_ff       <= 16'd0;
         last_ff       <= 1'b1;
         err_ff        <= (phase_ff == PH_ERROR);
         done_ff       <= !running_ff;
      end else if (cmd.load_word) begin
         word_valid_ff <= 1'b1;
         page_addr_ff  <= page_base_ff;
         offset_ff     <= 7'(off_lo);
         data_ff       <= {byte_hi, byte_lo};
         last_ff       <= sts.word_last;
         err_ff        <= (phase_ff == PH_ERROR);
         done_ff       <= !running_ff;
      end
   end

   assign sts.dump_pend = dump_ff;
   assign sts.word_last = (word_ff == KW'(WORDS - 1));
   assign sts.chk_err   = (phase_ff == PH_ERROR);
   assign sts.done      = !running_ff;

   assign rsp_word_valid     = word_valid_ff;
   assign rsp_page_address   = page_addr_ff;
   assign rsp_word_offset    = offset_ff;
   assign rsp_word_data      = data_ff;
   assign rsp_last_word      = last_ff;
   assign rsp_checksum_error = err_ff;
   assign rsp_load_done      = done_ff;

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for intel_hex_page_loader: feeds Intel HEX text one
// character per transaction and checks every status result and page word.
// Depends on ihpl_pkg and the intel_hex_page_loader RTL.
`timescale 1ns / 1ps

module tb_top;
   import ihpl_pkg::*;

   localparam int PAGE_BYTES   = 128;
   localparam int RANDOM_CHARS = 270;
   // a page dump is (PAGE_BYTES+1)/2 results, but every word is a transaction;
   // the longest quiet stretch is a sender gap plus a receiver stall plus latency
   localparam int IDLE_LIMIT   = 2000;
   localparam int TAIL_CYCLES  = 40;

   typedef struct packed {
      logic        word_valid;
      logic [15:0] page_address;
      logic [6:0]  word_offset;
      logic [15:0] word_data;
      logic        last_word;
      logic        checksum_error;
      logic        load_done;
   } page_result_type;

   typedef enum {END_CLEAN_EOF, END_BAD_EOF, END_BAD_RECORD} file_ending_type;

   // Parser and page buffer model plus the queue of results still owed.
   class load_scoreboard;
      ihpl_phase_type  phase;
      bit              running;
      bit              base_pending;
      bit [2:0]        digit_cnt;
      bit [15:0]       accum;
      bit [15:0]       page_base;
      bit [7:0]        rec_size;
      bit [7:0]        rec_type;
      bit [7:0]        rec_sum;
      bit [7:0]        rec_bytes;
      bit [7:0]        fill;
      bit [7:0]        page_buf [128];
      page_result_type step_q[$];
      page_result_type expected_q[$];
      int              mismatch_count;

      function new();
         phase = PH_START;
         running = 1'b1;
         base_pending = 1'b1;
         digit_cnt = '0;
         accum = '0;
         page_base = '0;
         rec_size = '0;
         rec_type = '0;
         rec_sum = '0;
         rec_bytes = '0;
         fill = '0;
         foreach (page_buf[i]) page_buf[i] = ERASED_BYTE;
         mismatch_count = 0;
      endfunction

      function bit [3:0] digit_value(bit [7:0] c);
         if (c >= 8'h30 && c <= 8'h39) return 4'(c - 8'h30);       // 0-9
         if (c >= 8'h41 && c <= 8'h46) return 4'(c - 8'h41 + 10);  // A-F
         if (c >= 8'h61 && c <= 8'h66) return 4'(c - 8'h61 + 10);  // a-f
         return 4'h0;
      endfunction

      function bit [7:0] stored_byte(int off);
         return (off < PAGE_BYTES) ? page_buf[off] : ERASED_BYTE;
      endfunction

      function void capture_page();
         page_result_type r;
         for (int k = 0; k < (PAGE_BYTES + 1) / 2; k++) begin
            r = '0;
            r.word_valid = 1'b1;
            r.page_address = page_base;
            r.word_offset = 7'(2 * k);
            r.word_data = {stored_byte(2 * k + 1), stored_byte(2 * k)};
            step_q.push_back(r);
         end
      endfunction

      function void note_char(bit [7:0] c);
         int              need;
         bit [15:0]       v;
         bit [7:0]        b;
         page_result_type r;
         step_q.delete();
         if (running && phase == PH_START) begin
            if (c == START_CHAR) begin
               phase = PH_SIZE;
               digit_cnt = '0;
               accum = '0;
               rec_sum = '0;
            end
         end else if (running && phase != PH_ERROR) begin
            need = (phase == PH_ADDRESS) ? 4 : 2;
            accum = {accum[11:0], digit_value(c)};
            digit_cnt = digit_cnt + 3'd1;
            if (digit_cnt >= need) begin
               v = accum;
               b = v[7:0];
               digit_cnt = '0;
               accum = '0;
               case (phase)
                  PH_SIZE: begin
                     rec_size = b;
                     rec_sum += b;
                     phase = PH_ADDRESS;
                  end
                  PH_ADDRESS: begin
                     rec_sum = rec_sum + b + v[15:8];
                     if (base_pending) begin
                        page_base = 16'(v - v % PAGE_BYTES);
                        base_pending = 1'b0;
                     end
                     phase = PH_TYPE;
                  end
                  PH_TYPE: begin
                     rec_type = b;
                     rec_sum += b;
                     rec_bytes = '0;
                     phase = (b == REC_EOF || rec_size == 0) ? PH_CHECKSUM : PH_DATA;
                  end
                  PH_DATA: begin
                     if (fill < 128) page_buf[fill] = b;
                     rec_sum += b;
                     fill++;
                     rec_bytes++;
                     if (rec_bytes == rec_size) begin
                        phase = PH_CHECKSUM;
                        rec_bytes = '0;
                     end
                     if (fill >= PAGE_BYTES) begin
                        capture_page();
                        foreach (page_buf[i]) page_buf[i] = ERASED_BYTE;
                        fill = '0;
                        base_pending = 1'b1;
                     end
                  end
                  default: begin
                     rec_sum += b;
                     // end of file dumps the buffer even with a bad checksum
                     if (rec_type == REC_EOF) begin
                        capture_page();
                        running = 1'b0;
                     end
                     phase = (rec_sum == 0) ? PH_START : PH_ERROR;
                  end
               endcase
            end
         end
         if (step_q.size() == 0) begin
            r = '0;
            step_q.push_back(r);
         end
         foreach (step_q[k]) begin
            step_q[k].last_word = (k == step_q.size() - 1);
            step_q[k].checksum_error = (phase == PH_ERROR);
            step_q[k].load_done = !running;
            expected_q.push_back(step_q[k]);
         end
      endfunction

      task report_mismatch(string msg);
         $display("[%0t] MISMATCH: %s", $time, msg);
         mismatch_count++;
      endtask

      task compare_field(string name, int got, int want);
         if (got != want) report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
      endtask

      task check_result(page_result_type got);
         page_result_type want;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("result with nothing pending, word_data %h",
                                      got.word_data));
            return;
         end
         want = expected_q.pop_front();
         compare_field("word_valid", got.word_valid, want.word_valid);
         compare_field("page_address", got.page_address, want.page_address);
         compare_field("word_offset", got.word_offset, want.word_offset);
         compare_field("word_data", got.word_data, want.word_data);
         compare_field("last_word", got.last_word, want.last_word);
         compare_field("checksum_error", got.checksum_error, want.checksum_error);
         compare_field("load_done", got.load_done, want.load_done);
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_char_in;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_word_valid;
   logic [15:0] rsp_page_address;
   logic [6:0]  rsp_word_offset;
   logic [15:0] rsp_word_data;
   logic        rsp_last_word;
   logic        rsp_checksum_error;
   logic        rsp_load_done;

   load_scoreboard sb;
   bit [7:0]       char_q[$];
   int             data_total;
   int             quiet_cycles;

   intel_hex_page_loader #(.PAGE_BYTES(PAGE_BYTES)) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_char_in        (req_char_in),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_word_valid     (rsp_word_valid),
      .rsp_page_address   (rsp_page_address),
      .rsp_word_offset    (rsp_word_offset),
      .rsp_word_data      (rsp_word_data),
      .rsp_last_word      (rsp_last_word),
      .rsp_checksum_error (rsp_checksum_error),
      .rsp_load_done      (rsp_load_done)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // ---- stimulus construction ----

   function automatic bit [7:0] non_hex_char();
      bit [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66));
      return c;
   endfunction

   function automatic bit [7:0] data_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // zero nibbles may go out as any non-hex character, which parses as 0
   task automatic push_digits(bit [7:0] b, bit lower, int nonhex_pct);
      bit [3:0] nib;
      bit [7:0] c;
      for (int h = 1; h >= 0; h--) begin
         nib = h ? b[7:4] : b[3:0];
         if (nib == 0 && $urandom_range(0, 99) < nonhex_pct) c = non_hex_char();
         else if (nib < 10) c = 8'h30 + nib;
         else c = (lower ? 8'h61 : 8'h41) + nib - 8'd10;
         char_q.push_back(c);
      end
   endtask

   task automatic add_record(bit [7:0] size, bit [15:0] addr, bit [7:0] kind, bit corrupt,
                             bit lower, int nonhex_pct);
      bit [7:0] sum;
      bit [7:0] d;
      char_q.push_back(START_CHAR);
      sum = size + addr[15:8] + addr[7:0] + kind;
      push_digits(size, lower, nonhex_pct);
      push_digits(addr[15:8], lower, nonhex_pct);
      push_digits(addr[7:0], lower, nonhex_pct);
      push_digits(kind, lower, nonhex_pct);
      if (kind != REC_EOF) begin
         for (int i = 0; i < size; i++) begin
            d = data_byte();
            sum += d;
            push_digits(d, lower, nonhex_pct);
            data_total++;
         end
      end
      sum = -sum;
      if (corrupt) sum ^= 8'($urandom_range(1, 255));
      push_digits(sum, lower, nonhex_pct);
   endtask

   task automatic add_noise(int n);
      bit [7:0] c;
      repeat (n) begin
         do c = 8'($urandom_range(0, 255)); while (c == START_CHAR);
         char_q.push_back(c);
      end
   endtask

   task automatic add_random_record(bit [7:0] kind, bit corrupt);
      bit [7:0] size;
      size = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, 40));
      add_record(size, 16'($urandom), kind, corrupt, 1'($urandom_range(0, 1)),
                 ($urandom_range(0, 3) == 0) ? 60 : 0);
   endtask

   task automatic build_stimulus();
      int              directed_len;
      bit [7:0]        kind;
      file_ending_type ending;
      // stray bytes before the first start mark, extremes included
      char_q.push_back(8'h00);
      char_q.push_back(8'hFF);
      char_q.push_back(8'h0D);
      // empty record at the top address, then a data record of the highest type
      add_record(8'd0, 16'hFFFF, 8'h00, 1'b0, 1'b1, 100);
      add_record(8'd2, 16'h0000, 8'hFF, 1'b0, 1'b0, 100);
      directed_len = char_q.size();
      // well-formed records with noise between; at least one full page
      while (char_q.size() < directed_len + RANDOM_CHARS || data_total < PAGE_BYTES + 16) begin
         if ($urandom_range(0, 3) == 0) add_noise($urandom_range(1, 3));
         kind = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(2, 255)) : 8'h00;
         add_random_record(kind, 1'b0);
      end
      // only one ending per run: the parser locks after it
      ending = file_ending_type'($urandom_range(0, 2));
      case (ending)
         END_CLEAN_EOF: add_random_record(REC_EOF, 1'b0);
         END_BAD_EOF:   add_random_record(REC_EOF, 1'b1);
         default: begin
            add_record(8'($urandom_range(1, 8)), 16'($urandom), 8'h00, 1'b1, 1'b0, 0);
            add_random_record(REC_EOF, 1'b0);
         end
      endcase
      repeat (12) char_q.push_back(8'($urandom_range(0, 255)));
   endtask

   // ---- drivers ----

   task automatic feed_chars();
      int gap;
      bit burst;
      burst = 1'b0;
      foreach (char_q[i]) begin
         if ($urandom_range(0, 29) == 0) burst = !burst;
         gap = burst ? 0 : $urandom_range(0, 9);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_char_in <= char_q[i];
         do @(posedge clock); while (!req_ready);
      end
      req_valid <= 1'b0;
   endtask

   task automatic drain_results();
      int stall;
      bit burst;
      burst = 1'b0;
      forever begin
         if ($urandom_range(0, 29) == 0) burst = !burst;
         stall = burst ? 0 : $urandom_range(0, 9);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   endtask

   // ---- monitors ----

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) sb.note_char(req_char_in);
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(page_result_type'({rsp_word_valid, rsp_page_address, rsp_word_offset,
                                            rsp_word_data, rsp_last_word, rsp_checksum_error,
                                            rsp_load_done}));
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_char_in <= 8'h00;
      rsp_ready <= 1'b0;
      quiet_cycles = 0;
      data_total = 0;
      sb = new();
      build_stimulus();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      fork
         drain_results();
      join_none
      feed_chars();
      @(posedge clock);
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
